// ===== hdl/mkcc_pkg.sv =====
// Shared types and constants for the multi-key click counter.
package mkcc_pkg;

	localparam int MAX_KEYS = 8;
	localparam int OUT_KEYS = 4;
	localparam int IDX_W    = 3;
	localparam int CNT_W    = 8;
	localparam int TMR_W    = 16;
	localparam int POS_W    = 3;

	localparam logic [CNT_W-1:0] CNT_MAX       = {CNT_W{1'b1}};
	localparam logic [TMR_W-1:0] TMR_MAX       = {TMR_W{1'b1}};
	localparam logic [TMR_W-1:0] RST_THRESHOLD = 16'd100;

	// Command codes
	localparam logic [1:0] CMD_SCAN     = 2'd0;
	localparam logic [1:0] CMD_RD_COUNT = 2'd1;
	localparam logic [1:0] CMD_RD_SAVED = 2'd2;

	typedef enum logic [1:0] {
		KS_IDLE     = 2'd0,
		KS_PRESSED  = 2'd1,
		KS_HOLD     = 2'd2,
		KS_RELEASED = 2'd3
	} key_state_t;

	// Per-lane control from the top level
	typedef struct packed {
		logic scan;
		logic save;
		logic level;
	} lane_ctl_t;

	// Per-lane status toward the merge stage
	typedef struct packed {
		key_state_t       state_nxt;
		logic [CNT_W-1:0] count;
		logic [CNT_W-1:0] saved;
	} lane_stat_t;

	// One result item
	typedef struct packed {
		key_state_t [OUT_KEYS-1:0] state;
		logic [POS_W-1:0]          down_position;
		logic [CNT_W-1:0]          read_value;
		logic                      count_is_zero;
	} result_t;

endpackage

// ===== hdl/mkcc_lane.sv =====
// One key lane: edge detect, press count, idle timer and saved count.
module mkcc_lane
	import mkcc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  lane_ctl_t        ctl,
	input  logic [TMR_W-1:0] threshold,
	output lane_stat_t       stat
);

	key_state_t       state_q, state_n;
	logic             last_q, last_n;
	logic [CNT_W-1:0] count_q, count_n;
	logic [TMR_W-1:0] timer_q, timer_n;
	logic             armed_q, armed_n;
	logic [CNT_W-1:0] saved_q;

	// Next lane state for a scan tick
	always_comb begin
		state_n = state_q;
		last_n  = last_q;
		count_n = count_q;
		timer_n = timer_q;
		armed_n = armed_q;
		if (ctl.level != last_q) begin
			last_n  = ctl.level;
			timer_n = '0;
			if (!ctl.level) begin
				armed_n = 1'b1;
				state_n = KS_PRESSED;
				if (count_q != CNT_MAX) begin
					count_n = count_q + 1'b1;
				end
			end else begin
				state_n = KS_RELEASED;
			end
		end else begin
			state_n = ctl.level ? KS_IDLE : KS_HOLD;
			// advance the idle timer and drop the count at threshold
			if (ctl.level && armed_q) begin
				if (timer_q != TMR_MAX) begin
					timer_n = timer_q + 1'b1;
				end
				if (timer_n >= threshold) begin
					count_n = '0;
					armed_n = 1'b0;
				end
			end
		end
	end

	// Hold lane state; update on scan, latch backup on a count read of a nonzero count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= KS_IDLE;
			last_q  <= 1'b1;
			count_q <= '0;
			timer_q <= '0;
			armed_q <= 1'b0;
			saved_q <= '0;
		end else begin
			if (ctl.scan) begin
				state_q <= state_n;
				last_q  <= last_n;
				count_q <= count_n;
				timer_q <= timer_n;
				armed_q <= armed_n;
			end
			if (ctl.save && count_q != '0) begin
				saved_q <= count_q;
			end
		end
	end

	assign stat.state_nxt = ctl.scan ? state_n : state_q;
	assign stat.count     = count_q;
	assign stat.saved     = saved_q;

endmodule

// ===== hdl/mkcc_merge.sv =====
// Merge stage: key states, lowest down key and read data across lanes.
module mkcc_merge
	import mkcc_pkg::*;
#(
	parameter int NUM_KEYS = 4
) (
	input  lane_stat_t       lanes [NUM_KEYS],
	input  logic [1:0]       cmd,
	input  logic [IDX_W-1:0] key_index,
	output result_t          res
);

	lane_stat_t          pad [MAX_KEYS];
	logic [MAX_KEYS-1:0] pad_ok;

	// Pad lanes out to the widest configuration; absent keys read idle
	for (genvar g = 0; g < MAX_KEYS; g++) begin : g_pad
		if (g < NUM_KEYS) begin : g_on
			assign pad[g]    = lanes[g];
			assign pad_ok[g] = 1'b1;
		end else begin : g_off
			assign pad[g]    = '{state_nxt: KS_IDLE, count: '0, saved: '0};
			assign pad_ok[g] = 1'b0;
		end
	end

	always_comb begin
		res = '0;
		for (int k = 0; k < OUT_KEYS; k++) begin
			res.state[k] = pad[k].state_nxt;
		end
		// find the lowest key that is down
		for (int k = MAX_KEYS - 1; k >= 0; k--) begin
			if (pad_ok[k] && (pad[k].state_nxt == KS_PRESSED ||
					pad[k].state_nxt == KS_HOLD)) begin
				res.down_position = POS_W'(k + 1);
			end
		end
		// select read data of the addressed key
		for (int k = 0; k < MAX_KEYS; k++) begin
			if (pad_ok[k] && key_index == IDX_W'(k)) begin
				unique case (cmd)
					CMD_RD_COUNT: begin
						res.read_value = pad[k].count;
					end
					CMD_RD_SAVED: begin
						res.read_value    = pad[k].saved;
						res.count_is_zero = (pad[k].count == '0);
					end
					default: begin
						res.read_value    = '0;
						res.count_is_zero = 1'b0;
					end
				endcase
			end
		end
	end

endmodule

// ===== hdl/multi_key_click_counter.sv =====
// Top level of the multi-key click counter: lanes, merge and output register.
//
// Channel   Direction  Handshake                 Payload
// in        to block   in_valid / in_stall       cmd, key_levels, key_index
// out       from block out_valid / out_stall     state_key0..3, down_position,
//                                                read_value, count_is_zero
// cfg       to block   cfg_valid / cfg_ready     release_threshold
//
// One item per cycle while in_stall is low; each result appears in the cycle after its item is taken.
// All keys are updated in parallel lanes in the accept cycle, and a single
// output register holds the merged result.
// in_stall is high only while a result waits in the output register and out_stall is high.
// Reset clears all key lanes and sets the threshold to 100; cfg_ready is always high.
module multi_key_click_counter
	import mkcc_pkg::*;
#(
	parameter int NUM_KEYS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          cmd,
	input  logic [3:0]          key_levels,
	input  logic [IDX_W-1:0]    key_index,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          state_key0,
	output logic [1:0]          state_key1,
	output logic [1:0]          state_key2,
	output logic [1:0]          state_key3,
	output logic [POS_W-1:0]    down_position,
	output logic [CNT_W-1:0]    read_value,
	output logic                count_is_zero,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [TMR_W-1:0]    release_threshold
);

	logic             accept;
	logic [TMR_W-1:0] thr_q;
	lane_ctl_t        lane_ctl  [NUM_KEYS];
	lane_stat_t       lane_stat [NUM_KEYS];
	result_t          res_n;
	result_t          res_s1;
	logic             valid_s1;

	assign in_stall  = valid_s1 && out_stall;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Hold the release threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= RST_THRESHOLD;
		end else if (cfg_valid) begin
			thr_q <= release_threshold;
		end
	end

	// Key lanes
	for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
		logic lvl;
		if (g < OUT_KEYS) begin : g_pin
			assign lvl = key_levels[g];
		end else begin : g_nopin
			assign lvl = 1'b1;
		end

		assign lane_ctl[g].scan  = accept && cmd == CMD_SCAN;
		assign lane_ctl[g].save  = accept && cmd == CMD_RD_COUNT &&
			key_index == IDX_W'(g);
		assign lane_ctl[g].level = lvl;

		mkcc_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (lane_ctl[g]),
			.threshold (thr_q),
			.stat      (lane_stat[g])
		);
	end

	mkcc_merge #(
		.NUM_KEYS (NUM_KEYS)
	) u_merge (
		.lanes     (lane_stat),
		.cmd       (cmd),
		.key_index (key_index),
		.res       (res_n)
	);

	// Output register: advance when empty or when the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res_n;
		end
	end

	assign out_valid     = valid_s1;
	assign state_key0    = res_s1.state[0];
	assign state_key1    = res_s1.state[1];
	assign state_key2    = res_s1.state[2];
	assign state_key3    = res_s1.state[3];
	assign down_position = res_s1.down_position;
	assign read_value    = res_s1.read_value;
	assign count_is_zero = res_s1.count_is_zero;

`ifndef SYNTHESIS
	// an accepted item always leaves a result in the output register
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted item produced no result");

	// scan ticks return no read data
	a_scan_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_SCAN) |=> (read_value == '0 && !count_is_zero))
		else $error("scan tick returned read data");

	// only the four pinned keys can ever be down
	a_down_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (down_position <= POS_W'(OUT_KEYS)))
		else $error("down position out of range");
`endif

endmodule

// ===== test/multi_key_click_counter_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the multi-key click counter: directed table, then random phases.
module multi_key_click_counter_tb;
	import mkcc_pkg::*;

	localparam int NUM_KEYS = 4;
	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SHOW_LIMIT = 10;
	localparam int DIR_ROWS = 22;
	localparam int HOLD_CYCLES = 150;

	// One row of the directed table; res is used only where known is set
	typedef struct packed {
		logic [1:0]       cmd;
		logic [3:0]       levels;
		logic [IDX_W-1:0] index;
		logic             known;
		result_t          res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] cmd = CMD_SCAN;
	logic [3:0] key_levels = 4'hF;
	logic [IDX_W-1:0] key_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] state_key0;
	logic [1:0] state_key1;
	logic [1:0] state_key2;
	logic [1:0] state_key3;
	logic [POS_W-1:0] down_position;
	logic [CNT_W-1:0] read_value;
	logic count_is_zero;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [TMR_W-1:0] threshold_wdata = RST_THRESHOLD;

	// Predictor copy of the key lanes and the threshold
	key_state_t       ks_now        [NUM_KEYS];
	logic             lvl_seen      [NUM_KEYS];
	logic [CNT_W-1:0] presses       [NUM_KEYS];
	logic [TMR_W-1:0] idle_scans    [NUM_KEYS];
	logic             armed         [NUM_KEYS];
	logic [CNT_W-1:0] presses_saved [NUM_KEYS];
	logic [TMR_W-1:0] clear_after;

	result_t click_expect_q [$];
	dir_row_t dir_rows [DIR_ROWS];

	int cycle_count = 0;
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int settings_used = 0;
	int long_holds = 0;

	// Sender and receiver pacing state
	int burst_left = 0;
	int quiet_left = 0;
	int scan_pct = 70;
	int toggle_pct = 30;
	int quiet_pct = 3;
	logic [3:0] held_levels = 4'hF;
	int hold_left = 0;
	int run_left = 0;
	logic run_stall = 1'b0;

	multi_key_click_counter #(
		.NUM_KEYS(NUM_KEYS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.key_levels(key_levels),
		.key_index(key_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.state_key0(state_key0),
		.state_key1(state_key1),
		.state_key2(state_key2),
		.state_key3(state_key3),
		.down_position(down_position),
		.read_value(read_value),
		.count_is_zero(count_is_zero),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.release_threshold(threshold_wdata)
	);

	// Generate the 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Build a result with every key in the same state
	function automatic result_t uniform_result(input key_state_t s, input logic [POS_W-1:0] pos,
			input logic [CNT_W-1:0] val, input logic z);
		result_t r;
		for (int k = 0; k < OUT_KEYS; k++) r.state[k] = s;
		r.down_position = pos;
		r.read_value = val;
		r.count_is_zero = z;
		return r;
	endfunction

	// Advance the key lanes by one item and return the result it causes
	function automatic result_t predict_click(input logic [1:0] c, input logic [3:0] lev,
			input logic [IDX_W-1:0] idx);
		result_t r;
		logic lv;
		r = '0;
		if (c == CMD_SCAN) begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				lv = (k < 4) ? lev[k] : 1'b1;
				if (lv != lvl_seen[k]) begin
					lvl_seen[k] = lv;
					idle_scans[k] = '0;
					if (!lv) begin
						armed[k] = 1'b1;
						ks_now[k] = KS_PRESSED;
						if (presses[k] != CNT_MAX) presses[k] = presses[k] + 1'b1;
					end else begin
						ks_now[k] = KS_RELEASED;
					end
				end else begin
					ks_now[k] = lv ? KS_IDLE : KS_HOLD;
				end
			end
			// Run the release timers of armed idle keys
			for (int k = 0; k < NUM_KEYS; k++) begin
				if (ks_now[k] == KS_IDLE && armed[k]) begin
					if (idle_scans[k] != TMR_MAX) idle_scans[k] = idle_scans[k] + 1'b1;
					if (idle_scans[k] >= clear_after) begin
						presses[k] = '0;
						armed[k] = 1'b0;
					end
				end
			end
		end else if (c == CMD_RD_COUNT) begin
			if (idx < NUM_KEYS) begin
				if (presses[idx] != '0) presses_saved[idx] = presses[idx];
				r.read_value = presses[idx];
			end
		end else if (c == CMD_RD_SAVED) begin
			if (idx < NUM_KEYS) begin
				r.count_is_zero = (presses[idx] == '0);
				r.read_value = presses_saved[idx];
			end
		end
		for (int k = 0; k < OUT_KEYS; k++) r.state[k] = (k < NUM_KEYS) ? ks_now[k] : KS_IDLE;
		for (int k = NUM_KEYS - 1; k >= 0; k--) begin
			if (ks_now[k] == KS_PRESSED || ks_now[k] == KS_HOLD) r.down_position = POS_W'(k + 1);
		end
		return r;
	endfunction

	// Pick the idle gap before the next item: mostly none, a few long
	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			burst_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Offer one item, wait for it to be taken, record what it should produce
	task automatic send_click(input logic [1:0] c, input logic [3:0] lev,
			input logic [IDX_W-1:0] idx, input logic known, input result_t typed);
		int gap;
		result_t r;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		key_levels <= lev;
		key_index <= idx;
		do begin
			@(posedge clk);
		end while (in_stall);
		r = predict_click(c, lev, idx);
		click_expect_q.push_back(known ? typed : r);
		items_sent++;
		@(negedge clk);
	endtask

	// Draw one random item: mostly press/release sequences, some reads and noise
	task automatic send_random();
		int r;
		logic [1:0] c;
		logic [3:0] lev;
		logic [IDX_W-1:0] idx;
		r = $urandom_range(0, 99);
		idx = ($urandom_range(0, 99) < 85) ? IDX_W'($urandom_range(0, 3)) :
			IDX_W'($urandom_range(4, 7));
		lev = 4'($urandom);
		if (r < scan_pct) begin
			c = CMD_SCAN;
			if (quiet_left > 0) begin
				quiet_left--;
				held_levels = 4'hF;
			end else if ($urandom_range(0, 99) < quiet_pct) begin
				// leave all keys up for a run of scans so the release timers can run out
				quiet_left = $urandom_range(10, 130);
				held_levels = 4'hF;
			end else if ($urandom_range(0, 99) < 5) begin
				held_levels = lev;
			end else begin
				for (int k = 0; k < 4; k++) begin
					if ($urandom_range(0, 99) < toggle_pct) held_levels[k] = ~held_levels[k];
				end
			end
			lev = held_levels;
		end else if (r < scan_pct + (100 - scan_pct) * 9 / 10) begin
			c = ($urandom_range(0, 1) != 0) ? CMD_RD_COUNT : CMD_RD_SAVED;
		end else begin
			c = CMD_NONE;
		end
		send_click(c, lev, idx, 1'b0, '0);
	endtask

	// Send a batch of random items and drain the results
	task automatic run_phase(input int n, input int scans, input int toggles, input int quiet);
		scan_pct = scans;
		toggle_pct = toggles;
		quiet_pct = quiet;
		repeat (n) send_random();
		in_valid <= 1'b0;
		while (click_expect_q.size() != 0) @(negedge clk);
	endtask

	// Write the release threshold while the block is idle
	task automatic write_threshold(input logic [TMR_W-1:0] v);
		cfg_valid <= 1'b1;
		threshold_wdata <= v;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		clear_after = v;
		settings_used++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stimulus: reset, directed table, then random phases over several thresholds
	initial begin
		dir_rows = '{
			'{CMD_SCAN,     4'hF, 3'd0, 1'b1, uniform_result(KS_IDLE, 0, 0, 0)},
			'{CMD_RD_COUNT, 4'hF, 3'd0, 1'b1, uniform_result(KS_IDLE, 0, 0, 0)},
			'{CMD_RD_SAVED, 4'hF, 3'd3, 1'b1, uniform_result(KS_IDLE, 0, 0, 1)},
			'{CMD_SCAN,     4'hE, 3'd0, 1'b0, '0},
			'{CMD_SCAN,     4'hE, 3'd7, 1'b0, '0},
			'{CMD_SCAN,     4'h0, 3'd0, 1'b0, '0},
			'{CMD_SCAN,     4'hF, 3'd0, 1'b0, '0},
			'{CMD_RD_COUNT, 4'h0, 3'd0, 1'b0, '0},
			'{CMD_RD_SAVED, 4'hF, 3'd0, 1'b0, '0},
			'{CMD_RD_COUNT, 4'hF, 3'd7, 1'b1, uniform_result(KS_RELEASED, 0, 0, 0)},
			'{CMD_RD_SAVED, 4'hF, 3'd4, 1'b1, uniform_result(KS_RELEASED, 0, 0, 0)},
			'{CMD_NONE,     4'h0, 3'd5, 1'b1, uniform_result(KS_RELEASED, 0, 0, 0)},
			'{CMD_SCAN,     4'hF, 3'd0, 1'b0, '0},
			'{CMD_SCAN,     4'h7, 3'd0, 1'b0, '0},
			'{CMD_SCAN,     4'h5, 3'd0, 1'b0, '0},
			'{CMD_SCAN,     4'hA, 3'd0, 1'b0, '0},
			'{CMD_SCAN,     4'hF, 3'd0, 1'b0, '0},
			'{CMD_RD_COUNT, 4'hF, 3'd3, 1'b0, '0},
			'{CMD_RD_SAVED, 4'hF, 3'd2, 1'b0, '0},
			'{CMD_RD_COUNT, 4'hF, 3'd1, 1'b0, '0},
			'{CMD_RD_SAVED, 4'hF, 3'd1, 1'b0, '0},
			'{CMD_SCAN,     4'hF, 3'd6, 1'b0, '0}
		};
		for (int k = 0; k < NUM_KEYS; k++) begin
			ks_now[k] = KS_IDLE;
			lvl_seen[k] = 1'b1;
			presses[k] = '0;
			idle_scans[k] = '0;
			armed[k] = 1'b0;
			presses_saved[k] = '0;
		end
		clear_after = RST_THRESHOLD;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			send_click(dir_rows[i].cmd, dir_rows[i].levels, dir_rows[i].index,
				dir_rows[i].known, dir_rows[i].res);
		end
		run_phase(100, 70, 30, 3);
		write_threshold(16'd1);
		run_phase(100, 70, 40, 2);
		write_threshold(16'd0);
		run_phase(80, 70, 40, 2);
		// fast toggling with no timeout drives the press counts into saturation
		write_threshold(TMR_MAX);
		run_phase(620, 95, 97, 0);
		write_threshold(TMR_W'($urandom_range(2, 12)));
		run_phase(100, 75, 30, 4);
		repeat (8) @(negedge clk);

		if (click_expect_q.size() != 0) begin
			errors++;
			$display("%0d results never arrived", click_expect_q.size());
		end
		$display("covered %0d items (%0d directed) over %0d threshold settings incl. 0 and max",
			items_sent, DIR_ROWS, settings_used + 1);
		$display("checked %0d results with %0d long output holds, %0d errors",
			results_seen, long_holds, errors);
		if (errors == 0) begin
			$display("multi_key_click_counter test passed");
		end else begin
			$display("multi_key_click_counter test failed");
		end
		$finish;
	end

	// Drive out_stall: random runs, free stretches and two long holds
	always @(negedge clk) begin
		int pick;
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (long_holds < 2 && results_seen >= 350 + 400 * long_holds) begin
			hold_left = HOLD_CYCLES - 1;
			long_holds++;
			out_stall <= 1'b1;
		end else if (run_left > 0) begin
			run_left--;
			out_stall <= run_stall;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				run_stall = 1'b0;
				run_left = 0;
			end else if (pick < 55) begin
				run_stall = 1'b0;
				run_left = $urandom_range(20, 80);
			end else if (pick < 85) begin
				run_stall = 1'b1;
				run_left = $urandom_range(0, 2);
			end else if (pick < 97) begin
				run_stall = 1'b1;
				run_left = $urandom_range(3, 11);
			end else begin
				run_stall = 1'b1;
				run_left = $urandom_range(29, 79);
			end
			out_stall <= run_stall;
		end
	end

	// Compare each accepted result with the oldest pending expectation
	always @(posedge clk) begin
		result_t want;
		if (out_valid && !out_stall) begin
			results_seen++;
			if (click_expect_q.size() == 0) begin
				errors++;
				if (errors <= SHOW_LIMIT) $display("cycle %0d: result with no item pending",
					cycle_count);
			end else begin
				want = click_expect_q.pop_front();
				if (state_key0 !== want.state[0] || state_key1 !== want.state[1] ||
						state_key2 !== want.state[2] || state_key3 !== want.state[3] ||
						down_position !== want.down_position ||
						read_value !== want.read_value || count_is_zero !== want.count_is_zero) begin
					errors++;
					if (errors <= SHOW_LIMIT) begin
						$display("cycle %0d: exp states %0d %0d %0d %0d pos %0d val %0d zero %0d",
							cycle_count, want.state[0], want.state[1], want.state[2],
							want.state[3], want.down_position, want.read_value,
							want.count_is_zero);
						$display("cycle %0d: got states %0d %0d %0d %0d pos %0d val %0d zero %0d",
							cycle_count, state_key0, state_key1, state_key2, state_key3,
							down_position, read_value, count_is_zero);
					end
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("multi_key_click_counter test failed");
			$finish;
		end
	end

endmodule
